// ===== design/bdsl_pkg.sv =====
// Package for the button debouncer with short/long press detection.
// Holds the state codes, register indexes, widths and the state record type.
// No dependencies.
package bdsl_pkg;

  localparam int unsigned ThrW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    STATE_NONE           = 3'd0,
    STATE_ENABLED        = 3'd1,
    STATE_ENABLED_SHORT  = 3'd2,
    STATE_ENABLED_LONG   = 3'd3,
    STATE_DISABLED       = 3'd4,
    STATE_DISABLED_SHORT = 3'd5,
    STATE_DISABLED_LONG  = 3'd6
  } button_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_SHORT   = 3'd0,
    REG_PRESS_LONG    = 3'd1,
    REG_RELEASE_SHORT = 3'd2,
    REG_RELEASE_LONG  = 3'd3
  } cfg_reg_e;

  localparam logic [ThrW-1:0] ShortReset = 10'd5;
  localparam logic [ThrW-1:0] LongReset  = 10'd100;

  typedef struct packed {
    logic [ThrW-1:0] press_short;
    logic [ThrW-1:0] press_long;
    logic [ThrW-1:0] release_short;
    logic [ThrW-1:0] release_long;
  } thresholds_t;

  typedef struct packed {
    logic            booted;
    logic [CntW-1:0] press_ticks;
    logic [CntW-1:0] release_ticks;
    button_state_e   code;
  } deb_state_t;

endpackage

// ===== design/button_debounce_short_long_press_top.sv =====
// Top level of the button debouncer with short/long press detection.
// Depends on bdsl_pkg and bdsl_core.
//
// Usage:
//   s_axis: one transfer per sample tick, tdata[0] = raw level,
//     1 pressed, 0 released.
//   m_axis: one transfer per input tick, tdata[0] = event flag (state changed),
//     tdata[3:1] = debounced state code after the tick.
//   cfg: write channel, index 0..3 selects press short/long and release
//     short/long thresholds in ticks; other indexes are ignored. Always ready.
//     Write only while idle.
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one tick per cycle when not stalled; the state update and
//   threshold compares are one combinational pass between state and result registers.
// Reset: thresholds return to 5/100/5/100, counters and state code clear,
//   and the next tick preloads the counter of the sampled level.
// Stall: the result register holds while m_axis_tready is low; a new tick
//   is taken in the same cycle the held result leaves.
module button_debounce_short_long_press_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [0] raw_pressed
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [0] event_res, [3:1] button_state
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bdsl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bdsl_pkg::ThrW-1:0]  cfg_data_i
);
  import bdsl_pkg::*;

  thresholds_t   thr_q;
  deb_state_t    state_q, state_d;
  logic          event_d, event_q;
  logic          out_valid_q;
  logic          in_xfer;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.press_short   <= ShortReset;
      thr_q.press_long    <= LongReset;
      thr_q.release_short <= ShortReset;
      thr_q.release_long  <= LongReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PRESS_SHORT:   thr_q.press_short   <= cfg_data_i;
        REG_PRESS_LONG:    thr_q.press_long    <= cfg_data_i;
        REG_RELEASE_SHORT: thr_q.release_short <= cfg_data_i;
        REG_RELEASE_LONG:  thr_q.release_long  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bdsl_core u_core (
    .thr_i     (thr_q),
    .state_i   (state_q),
    .pressed_i (s_axis_tdata[0]),
    .state_o   (state_d),
    .event_o   (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.booted        <= 1'b0;
      state_q.press_ticks   <= '0;
      state_q.release_ticks <= '0;
      state_q.code          <= STATE_NONE;
      out_valid_q           <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, state_q.code, event_q};

endmodule

// ===== design/bdsl_core.sv =====
// Next-state logic of the debouncer for one sample tick.
// Pure combinational; uses bdsl_pkg types and codes.
module bdsl_core (
  input  bdsl_pkg::thresholds_t thr_i,
  input  bdsl_pkg::deb_state_t  state_i,
  input  logic                  pressed_i,
  output bdsl_pkg::deb_state_t  state_o,
  output logic                  event_o
);
  import bdsl_pkg::*;

  logic [CntW-1:0] pt0, rt0, pt_inc, rt_inc;
  logic [CntW-1:0] ps, pl, rs, rl;

  assign ps = {1'b0, thr_i.press_short};
  assign pl = {1'b0, thr_i.press_long};
  assign rs = {1'b0, thr_i.release_short};
  assign rl = {1'b0, thr_i.release_long};

  // First tick preloads the counter of the current level
  assign pt0 = (!state_i.booted && pressed_i)  ? pl : state_i.press_ticks;
  assign rt0 = (!state_i.booted && !pressed_i) ? rl : state_i.release_ticks;

  assign pt_inc = pt0 + 1'b1;
  assign rt_inc = rt0 + 1'b1;

  always_comb begin
    state_o               = state_i;
    state_o.booted        = 1'b1;
    state_o.press_ticks   = pt0;
    state_o.release_ticks = rt0;
    event_o               = 1'b0;
    if (pressed_i) begin
      if (rt0 < rl && rs < rt0 && state_i.code != STATE_ENABLED_SHORT) begin
        state_o.code = STATE_ENABLED_SHORT;
        event_o      = 1'b1;
      end else begin
        if (pt0 <= pl) begin
          state_o.press_ticks = pt_inc;
          if (pt0 == pl) begin
            state_o.code = STATE_DISABLED_LONG;
            event_o      = 1'b1;
          end else if (pt_inc == ps) begin
            state_o.code = STATE_DISABLED;
            event_o      = 1'b1;
          end
        end
        if (!event_o) begin
          state_o.release_ticks = '0;
        end
      end
    end else begin
      if (pt0 < pl && ps < pt0 && state_i.code != STATE_DISABLED_SHORT) begin
        state_o.code = STATE_DISABLED_SHORT;
        event_o      = 1'b1;
      end else begin
        if (rt0 <= rl) begin
          state_o.release_ticks = rt_inc;
          if (rt0 == rl) begin
            if (state_i.code != STATE_ENABLED_LONG) begin
              state_o.code = STATE_ENABLED_LONG;
              event_o      = 1'b1;
            end
          end else if (rt_inc == rs) begin
            state_o.code = STATE_ENABLED;
            event_o      = 1'b1;
          end
        end
        if (!event_o) begin
          state_o.press_ticks = '0;
        end
      end
    end
  end

endmodule

// ===== dv/button_debounce_short_long_press_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_short_long_press_top.
// Drives ticks and threshold writes; checks results against a debounce predictor or typed rows.
// Depends on bdsl_pkg and the RTL of the top level.
module button_debounce_short_long_press_top_test;
  import bdsl_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned TickTarget    = 1600;
  localparam int unsigned HoldStart     = 1000;
  localparam int unsigned HoldLen       = 300;
  localparam int unsigned RxQuietLo     = 1700;
  localparam int unsigned RxQuietHi     = 2000;
  localparam int unsigned TxQuietLo     = 900;
  localparam int unsigned TxQuietHi     = 1200;
  localparam logic [CfgIdxW-1:0] IdxUnusedLo = 3'd4;
  localparam logic [CfgIdxW-1:0] IdxUnusedHi = 3'd7;
  localparam logic [ThrW-1:0]    ThrMax      = '1;

  typedef struct packed {
    logic          ev;
    button_state_e st;
  } tick_res_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [ThrW-1:0]    val;
    logic               raw;
    logic [7:0]         reps;
    logic               typed;
    tick_res_t          res;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [0] raw_pressed
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [0] event_res, [3:1] button_state
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [ThrW-1:0]     cfg_data_i    = '0;

  // predictor state
  thresholds_t         thr = '{ShortReset, LongReset, ShortReset, LongReset};
  logic                booted = 1'b0;
  logic [CntW-1:0]     press_cnt = '0;
  logic [CntW-1:0]     release_cnt = '0;
  button_state_e       code = STATE_NONE;

  tick_res_t           due_results [$];
  int unsigned         ticks_sent = 0;
  int unsigned         err_cnt = 0;
  int unsigned         stuck = 0;

  cfg_reg_e reg_order [4] = '{REG_PRESS_SHORT, REG_PRESS_LONG, REG_RELEASE_SHORT,
                              REG_RELEASE_LONG};

  dir_row_t dir_tab [15] = '{
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b1, 8'd1, 1'b1, '{1'b1, STATE_DISABLED_LONG}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b0, 8'd1, 1'b1, '{1'b0, STATE_DISABLED_LONG}},
    '{ROW_CFG, REG_PRESS_SHORT, 10'd2, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_CFG, REG_PRESS_LONG, 10'd5, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_CFG, REG_RELEASE_SHORT, 10'd2, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_CFG, REG_RELEASE_LONG, 10'd5, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_CFG, IdxUnusedHi, ThrMax, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_CFG, IdxUnusedLo, '0, 1'b0, 8'd0, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b0, 8'd6, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b1, 8'd3, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b0, 8'd1, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b1, 8'd6, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b0, 8'd3, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b1, 8'd1, 1'b0, '{1'b0, STATE_NONE}},
    '{ROW_TICK, REG_PRESS_SHORT, '0, 1'b0, 8'd3, 1'b0, '{1'b0, STATE_NONE}}
  };

  button_debounce_short_long_press_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic tick_res_t debounce_tick(input logic pressed);
    logic [CntW-1:0] prev;
    tick_res_t       r;
    r.ev = 1'b0;
    if (!booted) begin
      booted = 1'b1;
      if (pressed) press_cnt = {1'b0, thr.press_long};
      else release_cnt = {1'b0, thr.release_long};
    end
    if (pressed) begin
      if (release_cnt < thr.release_long && thr.release_short < release_cnt &&
          code != STATE_ENABLED_SHORT) begin
        code = STATE_ENABLED_SHORT;
        r.ev = 1'b1;
      end else begin
        if (press_cnt <= thr.press_long) begin
          prev = press_cnt;
          press_cnt = press_cnt + 1'b1;
          if (prev == thr.press_long) begin
            code = STATE_DISABLED_LONG;
            r.ev = 1'b1;
          end else if (press_cnt == thr.press_short) begin
            code = STATE_DISABLED;
            r.ev = 1'b1;
          end
        end
        if (!r.ev) release_cnt = '0;
      end
    end else begin
      if (press_cnt < thr.press_long && thr.press_short < press_cnt &&
          code != STATE_DISABLED_SHORT) begin
        code = STATE_DISABLED_SHORT;
        r.ev = 1'b1;
      end else begin
        if (release_cnt <= thr.release_long) begin
          prev = release_cnt;
          release_cnt = release_cnt + 1'b1;
          if (prev == thr.release_long) begin
            // long release only reports once
            if (code != STATE_ENABLED_LONG) begin
              code = STATE_ENABLED_LONG;
              r.ev = 1'b1;
            end
          end else if (release_cnt == thr.release_short) begin
            code = STATE_ENABLED;
            r.ev = 1'b1;
          end
        end
        if (!r.ev) press_cnt = '0;
      end
    end
    r.st = code;
    return r;
  endfunction

  task automatic send_tick(input logic raw, input logic typed, input tick_res_t typed_res);
    tick_res_t r;
    cfg_valid_i <= 1'b0;
    while (!(ticks_sent >= TxQuietLo && ticks_sent < TxQuietHi) &&
           $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    r = debounce_tick(raw);
    if (typed) r = typed_res;
    due_results.push_back(r);
    ticks_sent++;
  endtask

  // waits for the block to drain, then writes one config index (threshold or unused)
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PRESS_SHORT:   thr.press_short = val;
      REG_PRESS_LONG:    thr.press_long = val;
      REG_RELEASE_SHORT: thr.release_short = val;
      REG_RELEASE_LONG:  thr.release_long = val;
      default: ;
    endcase
  endtask

  initial begin
    int unsigned n, len, span, mode;
    logic        lvl;
    logic [ThrW-1:0] v;
    dir_row_t    row;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.val);
      else repeat (row.reps) send_tick(row.raw, row.typed, row.res);
    end
    while (ticks_sent < TickTarget) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) write_reg(CfgIdxW'(IdxUnusedLo + $urandom_range(0, 3)), ThrW'($urandom));
      for (int r = 0; r < 4; r++) begin
        case (mode)
          0:       v = $urandom_range(0, 1) ? ThrMax : '0;
          1:       v = ThrW'($urandom);
          default: v = ThrW'($urandom_range(0, 24));
        endcase
        write_reg(reg_order[r], v);
      end
      span = (thr.press_long > thr.release_long ? thr.press_long : thr.release_long) + 3;
      if (span > 40) span = 40;
      n = $urandom_range(60, 200);
      lvl = 1'($urandom_range(0, 1));
      // mostly steady runs around the thresholds, some bounce
      while (n > 0) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, span) : $urandom_range(1, 2);
        if (len > n) len = n;
        repeat (len) send_tick(lvl, 1'b0, '0);
        n -= len;
        lvl = !lvl;
      end
    end
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stall-free stretch
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) m_axis_tready <= 1'b0;
      else if (cyc >= RxQuietLo && cyc < RxQuietHi) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    tick_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result transfer, tdata=%h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[0] !== want.ev) begin
          $error("event_res: expected %0d, actual %0d", want.ev, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[3:1] !== want.st) begin
          $error("button_state: expected %0d, actual %0d", want.st, m_axis_tdata[3:1]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck <= 0;
    end else if (stuck == WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule

// ===== files.f =====
design/bdsl_pkg.sv
design/bdsl_core.sv
design/button_debounce_short_long_press_top.sv
dv/button_debounce_short_long_press_top_test.sv
